FILE: sv/assert_macros.svh
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled in reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: sv/aes_pkg.sv
package aes_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int SCHED_WORDS = 60;
	localparam int KEY_WIDTH = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_DECRYPT = 3'd1;
	localparam logic [2:0] REG_KEY0 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd5;

	localparam logic [0:0] OP_DATA = 1'b0;
	localparam logic [0:0] OP_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef logic [7:0] byte_t;

	function automatic byte_t dbl(input byte_t v);
		dbl = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t sbox(input byte_t x);
		byte_t t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	function automatic byte_t inv_sbox(input byte_t x);
		byte_t t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

endpackage

FILE: sv/aes_round.sv
// One AES round on a 128-bit state; byte 0 in the top bits, column-major.
module aes_round (
	input  logic         decrypt,
	input  logic         first,
	input  logic         last,
	input  logic [127:0] state,
	input  logic [127:0] rkey,
	output logic [127:0] result
);
	logic [7:0] s   [16];
	logic [7:0] sb  [16];
	logic [7:0] sr  [16];
	logic [7:0] mx  [16];
	logic [7:0] ak  [16];
	logic [7:0] fin [16];
	logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3, q0, q1, q2, q3, e0, e1, e2, e3;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state[127 - 8 * i -: 8];
		end
		// encrypt: sub, shift; decrypt: inv shift, inv sub
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (decrypt) begin
					sr[c * 4 + r] = aes_pkg::inv_sbox(s[((c + 3 * r) % 4) * 4 + r]);
				end else begin
					sr[c * 4 + r] = aes_pkg::sbox(s[((c + r) % 4) * 4 + r]);
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			sb[i] = sr[i];
			ak[i] = sb[i] ^ rkey[127 - 8 * i -: 8];
		end
		// encrypt mixes before the key, decrypt after it
		for (int c = 0; c < 4; c++) begin
			if (decrypt) begin
				a0 = ak[c * 4]; a1 = ak[c * 4 + 1]; a2 = ak[c * 4 + 2]; a3 = ak[c * 4 + 3];
			end else begin
				a0 = sb[c * 4]; a1 = sb[c * 4 + 1]; a2 = sb[c * 4 + 2]; a3 = sb[c * 4 + 3];
			end
			d0 = aes_pkg::dbl(a0); d1 = aes_pkg::dbl(a1);
			d2 = aes_pkg::dbl(a2); d3 = aes_pkg::dbl(a3);
			q0 = aes_pkg::dbl(d0); q1 = aes_pkg::dbl(d1);
			q2 = aes_pkg::dbl(d2); q3 = aes_pkg::dbl(d3);
			e0 = aes_pkg::dbl(q0); e1 = aes_pkg::dbl(q1);
			e2 = aes_pkg::dbl(q2); e3 = aes_pkg::dbl(q3);
			if (decrypt) begin
				// 0e 0b 0d 09
				mx[c*4]   = (e0^q0^d0) ^ (e1^d1^a1) ^ (e2^q2^a2) ^ (e3^a3);
				mx[c*4+1] = (e0^a0) ^ (e1^q1^d1) ^ (e2^d2^a2) ^ (e3^q3^a3);
				mx[c*4+2] = (e0^q0^a0) ^ (e1^a1) ^ (e2^q2^d2) ^ (e3^d3^a3);
				mx[c*4+3] = (e0^d0^a0) ^ (e1^q1^a1) ^ (e2^a2) ^ (e3^q3^d3);
			end else begin
				mx[c*4]   = d0 ^ d1 ^ a1 ^ a2 ^ a3;
				mx[c*4+1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
				mx[c*4+2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
				mx[c*4+3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (first) begin
				fin[i] = s[i] ^ rkey[127 - 8 * i -: 8];
			end else if (last) begin
				fin[i] = ak[i];
			end else if (decrypt) begin
				fin[i] = mx[i];
			end else begin
				fin[i] = mx[i] ^ rkey[127 - 8 * i -: 8];
			end
			result[127 - 8 * i -: 8] = fin[i];
		end
	end
endmodule

FILE: sv/aes_block_cipher_ecb.sv
// AES-128/192/256 in ECB mode, one message byte per input beat.
// Input channel: in_valid/in_stall with opcode and data_byte. opcode 0
// adds a byte; the sixteenth byte launches the block. opcode 1 in encrypt
// mode zero-pads a partial block and encrypts it; otherwise it is dropped.
// Output channel: out_valid/out_stall carries block_high/block_low.
// Config: cfg_we/cfg_index/cfg_data, to be written by the user only while
// the block is idle; the block itself does not enforce this. Writing
// key_size or a key register re-expands the schedule and empties the byte
// buffer; writing decrypt_mode keeps the buffer.
// Rounds: a launching beat runs Nr+1 round steps through the single round
// unit, one round key row read per cycle from the schedule rows, and the
// result is then written to the output register. No byte beat is accepted
// while the rounds run.
// Key expansion: key words load one per cycle, then one word per cycle
// through the word unit after reset and each key_size or key write;
// no beat accepted meanwhile.
// Reset clears control and expands the all-zero 128-bit key.
// Stall: a result waits in the output register until taken while bytes keep
// coming in; a block finished before that waits in the ST_OUT state,
// with in_stall high, and loads in the cycle after the register empties.
module aes_block_cipher_ecb #(
	parameter int BLOCK_BYTES = aes_pkg::BLOCK_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  opcode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_high,
	output logic [63:0] block_low,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int CW = $clog2(BLOCK_BYTES);

	aes_pkg::state_t state_q, state_d;
	logic [1:0]   key_size_q;
	logic         decrypt_q;
	logic [63:0]  key_q [4];
	logic [7:0]   buf_q [BLOCK_BYTES];
	logic [CW-1:0] count_q;
	logic [127:0] sched [aes_pkg::SCHED_WORDS / 4];
	logic [5:0]   wi_q;
	logic [31:0]  w_prev_q;
	logic [7:0]   rc_q;
	logic [3:0]   ki_q;
	logic [2:0]   kmod_q;
	logic [3:0]   rnd_q;
	logic [3:0]   nr;
	logic [3:0]   nk;
	logic [5:0]   total;
	logic [127:0] st_q, rk, rnd_out;
	logic [127:0] out_q;
	logic         out_valid_q;
	logic         acc_in, acc_out, launch, rekey;
	logic         first, last, dec_run_q;
	logic [31:0]  tw, sw, nw;
	logic [3:0]   rk_row;
	logic [5:0]   pw;

	assign nr = (key_size_q == 2'd0) ? 4'd10 : (key_size_q == 2'd1) ? 4'd12 : 4'd14;
	assign nk = (key_size_q == 2'd0) ? 4'd4 : (key_size_q == 2'd1) ? 4'd6 : 4'd8;
	assign total = {nr, 2'b00} + 6'd4;

	assign acc_in = in_valid && !in_stall;
	assign acc_out = out_valid && !out_stall;
	assign rekey = cfg_we && (cfg_index == aes_pkg::REG_KEY_SIZE ||
		(cfg_index >= aes_pkg::REG_KEY0 && cfg_index <= aes_pkg::REG_KEY3));
	assign launch = acc_in && ((opcode == aes_pkg::OP_DATA &&
		count_q == CW'(BLOCK_BYTES - 1)) || (opcode == aes_pkg::OP_FINISH &&
		!decrypt_q && count_q != '0));

	// round keys: one 128-bit schedule row per round step
	assign rk_row = dec_run_q ? nr - rnd_q : rnd_q;
	assign rk = sched[rk_row];
	assign first = (rnd_q == 4'd0);
	assign last = (rnd_q == nr);

	aes_round u_round (
		.decrypt(dec_run_q), .first(first), .last(last),
		.state(st_q), .rkey(rk), .result(rnd_out)
	);

	// key expansion word unit; word w sits in row w/4, word 0 of a row on top
	assign pw = wi_q - 6'(nk);
	always_comb begin
		tw = w_prev_q;
		if (kmod_q == 3'd0) begin
			sw = {aes_pkg::sbox(tw[23:16]), aes_pkg::sbox(tw[15:8]),
				aes_pkg::sbox(tw[7:0]), aes_pkg::sbox(tw[31:24])};
			tw = sw ^ {rc_q, 24'd0};
		end else if (nk == 4'd8 && kmod_q == 3'd4) begin
			sw = {aes_pkg::sbox(tw[31:24]), aes_pkg::sbox(tw[23:16]),
				aes_pkg::sbox(tw[15:8]), aes_pkg::sbox(tw[7:0])};
			tw = sw;
		end else begin
			sw = tw;
		end
		nw = sched[pw[5:2]][{~pw[1:0], 5'd0} +: 32] ^ tw;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aes_pkg::ST_EXPAND: if (wi_q >= total) state_d = aes_pkg::ST_IDLE;
			aes_pkg::ST_IDLE:   if (launch) state_d = aes_pkg::ST_ROUND;
			aes_pkg::ST_ROUND: begin
				if (last) state_d = out_valid_q ? aes_pkg::ST_OUT : aes_pkg::ST_IDLE;
			end
			aes_pkg::ST_OUT:    if (!out_valid_q) state_d = aes_pkg::ST_IDLE;
			default:            state_d = aes_pkg::ST_IDLE;
		endcase
		if (rekey) state_d = aes_pkg::ST_EXPAND;
	end

	always_comb begin
		in_stall = (state_q != aes_pkg::ST_IDLE);
		out_valid = out_valid_q;
	end
	assign block_high = out_q[127:64];
	assign block_low = out_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_EXPAND;
			key_size_q <= '0;
			decrypt_q <= 1'b0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			count_q <= '0;
			wi_q <= 6'd0;
			rc_q <= 8'h01;
			kmod_q <= 3'd0;
			ki_q <= 4'd0;
			rnd_q <= 4'd0;
			dec_run_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					aes_pkg::REG_KEY_SIZE: key_size_q <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
					aes_pkg::REG_DECRYPT:  decrypt_q <= cfg_data[0];
					default: if (rekey) key_q[2'(cfg_index - aes_pkg::REG_KEY0)] <= cfg_data;
				endcase
			end
			if (rekey) begin
				count_q <= '0;
				wi_q <= 6'd0;
				ki_q <= 4'd0;
				rc_q <= 8'h01;
				kmod_q <= 3'd0;
			end else if (state_q == aes_pkg::ST_EXPAND) begin
				wi_q <= wi_q + 6'd1;
				if (ki_q < nk) begin
					ki_q <= ki_q + 4'd1;
				end else begin
					kmod_q <= (kmod_q == 3'(nk - 4'd1)) ? 3'd0 : kmod_q + 3'd1;
					if (kmod_q == 3'd0) rc_q <= aes_pkg::dbl(rc_q);
				end
			end
			if (acc_in) begin
				if (launch) begin
					count_q <= '0;
					rnd_q <= 4'd0;
					dec_run_q <= decrypt_q && opcode == aes_pkg::OP_DATA;
				end else if (opcode == aes_pkg::OP_DATA) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (state_q == aes_pkg::ST_ROUND) rnd_q <= rnd_q + 4'd1;
			// output register fills only when empty, so a load never meets a take
			if ((state_q == aes_pkg::ST_ROUND && last && !out_valid_q) ||
				(state_q == aes_pkg::ST_OUT && !out_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (acc_out) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// schedule rows and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == aes_pkg::ST_EXPAND && !rekey && wi_q < total) begin
			if (ki_q < nk) begin
				sched[wi_q[5:2]][{~wi_q[1:0], 5'd0} +: 32] <=
					key_q[ki_q[2:1]][ki_q[0] ? 31 : 63 -: 32];
				w_prev_q <= key_q[ki_q[2:1]][ki_q[0] ? 31 : 63 -: 32];
			end else begin
				sched[wi_q[5:2]][{~wi_q[1:0], 5'd0} +: 32] <= nw;
				w_prev_q <= nw;
			end
		end
		if (acc_in && opcode == aes_pkg::OP_DATA) buf_q[count_q] <= data_byte;
		if (launch) begin
			for (int i = 0; i < BLOCK_BYTES; i++) begin
				if (opcode == aes_pkg::OP_DATA && i == BLOCK_BYTES - 1)
					st_q[127 - 8 * i -: 8] <= data_byte;
				else if (opcode == aes_pkg::OP_FINISH && CW'(i) >= count_q)
					st_q[127 - 8 * i -: 8] <= 8'h00;
				else
					st_q[127 - 8 * i -: 8] <= buf_q[i];
			end
		end else if (state_q == aes_pkg::ST_ROUND) begin
			st_q <= rnd_out;
			if (last && !out_valid_q) out_q <= rnd_out;
		end else if (state_q == aes_pkg::ST_OUT && !out_valid_q) begin
			out_q <= st_q;
		end
	end
endmodule

FILE: sv/aes_ecb_checker.sv
`include "assert_macros.svh"
module aes_ecb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [63:0] block_high,
	input logic [63:0] block_low
);
	`CHK_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid, "stalled input dropped")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({block_high, block_low}), "stalled result changed")
	`CHK_NEXT(a_out_one, clk, arst_n, out_valid && !out_stall, !out_valid, "result repeated")
	`CHK_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown({block_high, block_low}), "unknown result bits")
endmodule

bind aes_block_cipher_ecb aes_ecb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.block_high(block_high), .block_low(block_low)
);

FILE: dv/aes_block_cipher_ecb_tb.sv
`timescale 1ns / 1ps

module aes_block_cipher_ecb_tb;

	localparam int WDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [0:0] op;
		logic [7:0] data;
	} msg_beat_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_block_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [0:0]  opcode;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	aes_block_cipher_ecb u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.block_high(block_high), .block_low(block_low),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// stimulus and scoreboard
	msg_beat_t     beat_q[$];
	cipher_block_t block_q[$];
	int            idle_pct;
	int            stall_pct;
	bit            hold_go;
	bit            hold_done;
	int            hold_cnt;
	int            wdog_cnt;
	int            err_cnt = 0;

	// cipher mirror: tables, config and state
	logic [7:0]  fbox[256];
	logic [7:0]  ibox[256];
	logic [1:0]  m_ksize;
	logic        m_decrypt;
	logic [63:0] m_key[4];
	logic [7:0]  m_buf[16];
	int          m_cnt;
	logic [31:0] m_sched[60];
	logic [7:0]  st[16];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = xt(a);
		end
		return acc;
	endfunction

	// S-box and inverse S-box built from the field inverse plus the affine map
	function automatic void build_boxes();
		logic [7:0] inv;
		logic [7:0] b;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (x != 0 && gfmul(8'(x), 8'(y)) == 8'h01)
					inv = 8'(y);
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fbox[x] = b;
			ibox[b] = 8'(x);
		end
	endfunction

	function automatic int num_rounds();
		return 10 + 2 * ((m_ksize > 2) ? 2 : m_ksize);
	endfunction

	function automatic logic [31:0] subw(input logic [31:0] w);
		return {fbox[w[31:24]], fbox[w[23:16]], fbox[w[15:8]], fbox[w[7:0]]};
	endfunction

	function automatic void expand_sched();
		int nk;
		logic [31:0] t;
		logic [7:0] rc;
		nk = 4 + 2 * ((m_ksize > 2) ? 2 : m_ksize);
		rc = 8'h01;
		for (int i = 0; i < 60; i++)
			m_sched[i] = 32'h0;
		for (int i = 0; i < nk; i++)
			m_sched[i] = i[0] ? m_key[i >> 1][31:0] : m_key[i >> 1][63:32];
		for (int i = nk; i < 4 * (num_rounds() + 1); i++) begin
			t = m_sched[i - 1];
			if (i % nk == 0) begin
				t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = xt(rc);
			end else if (nk == 8 && i % nk == 4) begin
				t = subw(t);
			end
			m_sched[i] = m_sched[i - nk] ^ t;
		end
	endfunction

	function automatic void add_rk(input int rnd);
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = m_sched[(rnd * 4 + c) % 60];
			for (int r = 0; r < 4; r++)
				st[c * 4 + r] ^= w[31 - 8 * r -: 8];
		end
	endfunction

	function automatic void shift(input int dir);
		logic [7:0] t[16];
		t = st;
		for (int c = 0; c < 4; c++)
			for (int r = 1; r < 4; r++)
				st[c * 4 + r] = t[((c + r * dir) & 3) * 4 + r];
	endfunction

	function automatic void mix(input bit inverse);
		logic [7:0] m[4];
		logic [7:0] col[4];
		logic [7:0] v;
		if (inverse)
			m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else
			m = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++)
				col[k] = st[c * 4 + k];
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++)
					v ^= gfmul(col[k], m[(k + 4 - r) & 3]);
				st[c * 4 + r] = v;
			end
		end
	endfunction

	function automatic void cipher_state(input bit inverse);
		int nr;
		nr = num_rounds();
		if (!inverse) begin
			add_rk(0);
			for (int rd = 1; rd <= nr; rd++) begin
				for (int i = 0; i < 16; i++)
					st[i] = fbox[st[i]];
				shift(1);
				if (rd != nr)
					mix(1'b0);
				add_rk(rd);
			end
		end else begin
			add_rk(nr);
			for (int rd = nr - 1; rd >= 0; rd--) begin
				shift(3);
				for (int i = 0; i < 16; i++)
					st[i] = ibox[st[i]];
				add_rk(rd);
				if (rd != 0)
					mix(1'b1);
			end
		end
	endfunction

	function automatic void queue_block();
		cipher_block_t b;
		for (int i = 0; i < 8; i++) begin
			b.hi[63 - 8 * i -: 8] = st[i];
			b.lo[63 - 8 * i -: 8] = st[i + 8];
		end
		block_q.push_back(b);
	endfunction

	// Mirror of one accepted message beat.
	function automatic void ecb_step(input logic [0:0] op, input logic [7:0] d);
		if (op == aes_pkg::OP_FINISH) begin
			if (m_decrypt || m_cnt == 0)
				return;
			for (int i = 0; i < 16; i++)
				st[i] = (i < m_cnt) ? m_buf[i] : 8'h00;
			cipher_state(1'b0);
			queue_block();
			m_cnt = 0;
			return;
		end
		m_buf[m_cnt] = d;
		if (m_cnt < 15) begin
			m_cnt++;
			return;
		end
		m_cnt = 0;
		st = m_buf;
		cipher_state(m_decrypt);
		queue_block();
	endfunction

	// Driver: presents the head of beat_q, pops it once accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= aes_pkg::OP_DATA;
			data_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall) begin
				ecb_step(opcode, data_byte);
				void'(beat_q.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (beat_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					opcode <= beat_q[0].op;
					data_byte <= beat_q[0].data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest expected block and drives out_stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (block_q.size() == 0) begin
					$error("unexpected result block %h_%h", block_high, block_low);
					err_cnt++;
				end else begin
					if (block_high !== block_q[0].hi) begin
						$error("block_high expected %h actual %h", block_q[0].hi, block_high);
						err_cnt++;
					end
					if (block_low !== block_q[0].lo) begin
						$error("block_low expected %h actual %h", block_q[0].lo, block_low);
						err_cnt++;
					end
					void'(block_q.pop_front());
				end
			end
			// long back-pressure stretch, requested once
			if (hold_go && !hold_done) begin
				hold_done <= 1'b1;
				hold_cnt <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog on cycles with no beat or register write.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			wdog_cnt <= 0;
		end else if (wdog_cnt >= WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			wdog_cnt <= wdog_cnt + 1;
		end
	end

	// Register write while idle; key writes wait out the schedule expansion.
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == aes_pkg::REG_KEY_SIZE) begin
			m_ksize = val[1:0];
		end else if (idx == aes_pkg::REG_DECRYPT) begin
			m_decrypt = val[0];
		end else if (idx >= aes_pkg::REG_KEY0 && idx <= aes_pkg::REG_KEY3) begin
			m_key[2'(idx - aes_pkg::REG_KEY0)] = val;
		end
		if (idx != aes_pkg::REG_DECRYPT && idx <= aes_pkg::REG_KEY3) begin
			expand_sched();
			m_cnt = 0;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_beat(input logic [0:0] op, input logic [7:0] d);
		msg_beat_t b;
		b.op = op;
		b.data = d;
		beat_q.push_back(b);
	endtask

	task automatic drain();
		wait (beat_q.size() == 0 && block_q.size() == 0 && !in_valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [63:0] kv;
		int mode;
		int fin_pct;
		cfg_we = 1'b0;
		cfg_index = aes_pkg::REG_KEY_SIZE;
		cfg_data = 64'h0;
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b0;
		build_boxes();
		m_ksize = 2'd0;
		m_decrypt = 1'b0;
		m_cnt = 0;
		for (int i = 0; i < 4; i++)
			m_key[i] = 64'h0;
		for (int i = 0; i < 16; i++)
			m_buf[i] = 8'h00;
		expand_sched();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// directed: zero key, all-zero block, finish on empty buffer,
		// padded finish, all-ones bytes
		for (int i = 0; i < 16; i++)
			push_beat(aes_pkg::OP_DATA, 8'h00);
		push_beat(aes_pkg::OP_FINISH, 8'hff);
		push_beat(aes_pkg::OP_DATA, 8'hff);
		push_beat(aes_pkg::OP_DATA, 8'h80);
		push_beat(aes_pkg::OP_FINISH, 8'h00);
		for (int i = 0; i < 5; i++)
			push_beat(aes_pkg::OP_DATA, 8'hff);
		drain();
		// direction change mid-message keeps the buffer; finish is a no-op
		reg_write(aes_pkg::REG_DECRYPT, 64'h1);
		push_beat(aes_pkg::OP_FINISH, 8'h00);
		for (int i = 0; i < 11; i++)
			push_beat(aes_pkg::OP_DATA, 8'h01 << (i % 8));
		drain();
		// unused register indexes are ignored
		reg_write(3'd6, '1);
		reg_write(3'd7, '1);

		// random phases over key sizes (3 included), directions, idling and back-pressure
		for (int p = 0; p < 8; p++) begin
			mode = (p + 1) % 4;
			reg_write(aes_pkg::REG_KEY_SIZE, 64'(p % 4));
			reg_write(aes_pkg::REG_DECRYPT, 64'(p[0] ^ p[2]));
			if (p != 4) begin
				for (int k = 0; k < 4; k++) begin
					kv = (p == 7) ? '1 : (p == 0 && k == 0) ? '0 : {$urandom, $urandom};
					reg_write(3'(aes_pkg::REG_KEY0 + k), kv);
				end
			end
			idle_pct = (mode == 1) ? 65 : (mode == 3) ? 32 : 0;
			stall_pct = (mode == 2) ? 65 : (mode == 3) ? 32 : 0;
			fin_pct = (p[0] ^ p[2]) ? 2 : 5;
			if (mode == 0 && p < 4)
				hold_go = 1'b1;
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(99) < fin_pct)
					push_beat(aes_pkg::OP_FINISH, 8'($urandom_range(255)));
				else
					push_beat(aes_pkg::OP_DATA, 8'($urandom_range(255)));
			end
			drain();
		end

		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/aes_pkg.sv
sv/aes_round.sv
sv/aes_block_cipher_ecb.sv
sv/aes_ecb_checker.sv
dv/aes_block_cipher_ecb_tb.sv
